FILE: rtl/mtb_pkg.sv
// Shared types, constants and the gray conversion function for the mean threshold binarizer.
package mtb_pkg;

  localparam int unsigned MAX_PIXELS = 4194304;
  localparam int unsigned SUM_W      = 30;
  localparam int unsigned CNT_W      = 23;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned STEP_W     = 3;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

  // register indexes
  localparam logic CFG_OFFSET   = 1'b0;
  localparam logic CFG_POLARITY = 1'b1;

  // item kinds
  localparam logic KIND_ACCUM    = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quotient;
  } div_rsp_t;

  // (r+g+b)/3, exact for sums up to 765: x*683 >> 11
  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [9:0]  s;
    logic [18:0] p;
    s = 10'(r) + 10'(g) + 10'(b);
    p = 19'(s) * 19'd683;
    return p[18:11];
  endfunction

endpackage

FILE: rtl/mtb_div.sv
// Iterative restoring divider: one quotient bit per cycle, 8-bit quotient.
module mtb_div import mtb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  dsh_q, dsh_d;
  logic [PIX_W-1:0]  quo_q, quo_d;
  logic              ge;

  assign ge = rem_q >= dsh_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = req_i.dividend;
      dsh_d  = SUM_W'({req_i.divisor, {(PIX_W-1){1'b0}}});
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (rem_q - dsh_q) : rem_q;
      dsh_d  = dsh_q >> 1;
      quo_d  = {quo_q[PIX_W-2:0], ge};
      step_d = step_q + STEP_W'(1);
      if (step_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/mean_threshold_binarizer_unit.sv
// Global mean threshold binarizer: accumulate pass, mean division, classify pass.
// Accumulate items give no result; classify items give one result each against
// the held frame mean. The first classify item after any accumulate item starts
// the mean division (sum over count) on an iterative divider that yields one
// quotient bit per cycle, so that item holds the input off until the quotient
// is done. An empty frame skips the division and uses a mean of 0. Input is
// taken only while the output register is empty or being emptied in the same
// cycle.
module mean_threshold_binarizer_unit import mtb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [PIX_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic             first_i,
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             white_o,
  output logic [PIX_W-1:0] frame_mean_o
);

  state_e           state_q, state_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PIX_W-1:0] mean_q, mean_d;
  logic             mean_rdy_q, mean_rdy_d;
  logic [PIX_W-1:0] offset_q;
  logic             dark_q;
  logic [PIX_W-1:0] gray_q, gray_d;
  logic             out_valid_q, out_valid_d;
  logic             white_q, white_d;
  logic [PIX_W-1:0] fmean_q, fmean_d;

  logic             fire;
  logic             need_div;
  logic [PIX_W-1:0] gray_in;
  logic [SUM_W-1:0] base_sum;
  logic [CNT_W-1:0] base_cnt;
  logic             produce;
  logic [PIX_W-1:0] use_mean;
  logic [PIX_W-1:0] use_gray;
  logic [PIX_W-1:0] thr;
  logic             below;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign gray_in  = gray_of(red_i, green_i, blue_i);
  assign fire     = in_valid_i & in_ready_o;
  assign need_div = (kind_i == KIND_CLASSIFY) & ~mean_rdy_q & (cnt_q != '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (fire && need_div) state_d = ST_DIV;
      ST_DIV:  if (div_rsp.done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_q;
    div_req.divisor  = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = ~out_valid_q | out_ready_i;
        div_req.start = fire & need_div;
      end
      ST_DIV: begin
        in_ready_o    = 1'b0;
      end
      default: begin
        in_ready_o    = 1'b0;
      end
    endcase
  end

  mtb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // datapath
  always_comb begin
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    mean_d     = mean_q;
    mean_rdy_d = mean_rdy_q;
    gray_d     = gray_q;
    produce    = 1'b0;
    use_mean   = mean_q;
    use_gray   = gray_in;
    base_sum   = first_i ? '0 : sum_q;
    base_cnt   = first_i ? '0 : cnt_q;

    if (fire && kind_i == KIND_ACCUM) begin
      sum_d = base_sum;
      cnt_d = base_cnt;
      if (base_cnt < MAX_CNT) begin
        sum_d = base_sum + SUM_W'(gray_in);
        cnt_d = base_cnt + CNT_W'(1);
      end
      mean_rdy_d = 1'b0;
    end else if (fire) begin
      if (mean_rdy_q) begin
        produce = 1'b1;
      end else if (cnt_q == '0) begin
        mean_d     = '0;
        mean_rdy_d = 1'b1;
        use_mean   = '0;
        produce    = 1'b1;
      end else begin
        gray_d = gray_in;
      end
    end else if (state_q == ST_DIV && div_rsp.done) begin
      mean_d     = div_rsp.quotient;
      mean_rdy_d = 1'b1;
      use_mean   = div_rsp.quotient;
      use_gray   = gray_q;
      produce    = 1'b1;
    end

    thr         = use_mean - offset_q;
    below       = use_gray < thr;
    out_valid_d = (out_valid_q & ~out_ready_i) | produce;
    white_d     = produce ? (dark_q ? below : ~below) : white_q;
    fmean_d     = produce ? use_mean : fmean_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      mean_q      <= '0;
      mean_rdy_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      mean_q      <= mean_d;
      mean_rdy_q  <= mean_rdy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      dark_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET:   offset_q <= cfg_wdata_i;
        CFG_POLARITY: dark_q   <= cfg_wdata_i[0];
        default:      offset_q <= offset_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    gray_q  <= gray_d;
    white_q <= white_d;
    fmean_q <= fmean_d;
  end

  assign out_valid_o  = out_valid_q;
  assign white_o      = white_q;
  assign frame_mean_o = fmean_q;

endmodule

FILE: rtl/mtb_checker.sv
// Port-level checker for the mean threshold binarizer, bound to the top level.
module mtb_checker import mtb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic             cfg_idx_i,
  input logic [PIX_W-1:0] cfg_wdata_i,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             kind_i,
  input logic             first_i,
  input logic [PIX_W-1:0] red_i,
  input logic [PIX_W-1:0] green_i,
  input logic [PIX_W-1:0] blue_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             white_o,
  input logic [PIX_W-1:0] frame_mean_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(white_o)
      && $stable(frame_mean_o))
    else $error("result item changed while stalled");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output register is blocked");

  a_accum_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_ACCUM |=> !out_valid_o)
    else $error("accumulate item produced a result");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind mean_threshold_binarizer_unit mtb_checker u_mtb_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for the mean threshold binarizer unit.
`timescale 1ns / 1ps

module tb_top;
  import mtb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam int unsigned SETTLE_CYC   = 20;
  localparam int unsigned LONG_HOLD    = 400;

  typedef struct {
    bit             white;
    bit [PIX_W-1:0] mean;
  } bin_px_t;

  class threshold_checker;
    bit [PIX_W-1:0] offset_q;
    bit             dark_white_q;
    bit [SUM_W-1:0] gray_sum;
    bit [CNT_W-1:0] pix_cnt;
    bit [PIX_W-1:0] mean_q;
    bit             mean_ok;
    bin_px_t        exp_px[$];
    int             errors;
    int             results_seen;

    function new();
      offset_q     = '0;
      dark_white_q = 1'b1;
      gray_sum     = '0;
      pix_cnt      = '0;
      mean_q       = '0;
      mean_ok      = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic idx, logic [PIX_W-1:0] data);
      if (idx == CFG_OFFSET) offset_q = data;
      else dark_white_q = data[0];
    endfunction

    function int pending();
      return exp_px.size();
    endfunction

    function void note_pixel(logic kind, logic is_first, logic [PIX_W-1:0] r,
                             logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
      bit [9:0]       rgb_sum;
      bit [PIX_W-1:0] gray;
      bit [PIX_W-1:0] thr;
      bit             below;
      bin_px_t        px;
      rgb_sum = 10'(r) + 10'(g) + 10'(b);
      gray    = PIX_W'(rgb_sum / 10'd3);
      if (kind == KIND_ACCUM) begin
        if (is_first) begin
          gray_sum = '0;
          pix_cnt  = '0;
        end
        if (pix_cnt < MAX_CNT) begin
          gray_sum = gray_sum + SUM_W'(gray);
          pix_cnt  = pix_cnt + 1'b1;
        end
        mean_ok = 1'b0;
      end else begin
        if (!mean_ok) begin
          mean_q  = (pix_cnt == 0) ? '0 : PIX_W'(gray_sum / SUM_W'(pix_cnt));
          mean_ok = 1'b1;
        end
        thr      = mean_q - offset_q;
        below    = gray < thr;
        px.white = dark_white_q ? below : !below;
        px.mean  = mean_q;
        exp_px.push_back(px);
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_pixel(logic white, logic [PIX_W-1:0] mean);
      bin_px_t px;
      results_seen++;
      if (exp_px.size() == 0) begin
        report_mismatch($sformatf("unexpected item white=%0b mean=%0d", white, mean));
      end else begin
        px = exp_px.pop_front();
        if (white !== px.white)
          report_mismatch($sformatf("white %0b, expected %0b (mean %0d)",
                                    white, px.white, px.mean));
        if (mean !== px.mean)
          report_mismatch($sformatf("frame_mean %0d, expected %0d", mean, px.mean));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [PIX_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             kind_i;
  logic             first_i;
  logic [PIX_W-1:0] red_i;
  logic [PIX_W-1:0] green_i;
  logic [PIX_W-1:0] blue_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             white_o;
  logic [PIX_W-1:0] frame_mean_o;

  threshold_checker sb = new();
  bit               no_gaps;
  int unsigned      cycles;

  mean_threshold_binarizer_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .first_i      (first_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .white_o      (white_o),
    .frame_mean_o (frame_mean_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && in_ready_o)
        sb.note_pixel(kind_i, first_i, red_i, green_i, blue_i);
      if (out_valid_o && out_ready_i) sb.check_pixel(white_o, frame_mean_o);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_chan();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // receiver: random runs and stalls, plus one long hold-off to back up the input
  initial begin
    bit          long_hold_done;
    int unsigned run_len;
    int unsigned stall;
    int unsigned r;
    long_hold_done = 1'b0;
    out_ready_i    = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!long_hold_done && sb.results_seen >= 80) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_done = 1'b1;
      end
      run_len = $urandom_range(1, 60);
      out_ready_i <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      r = $urandom_range(0, 99);
      stall = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(10, 40);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  task automatic send_pixel(logic kind, logic is_first, logic [PIX_W-1:0] r,
                            logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    first_i    <= is_first;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // let the sampling edge pass first so the last accepted item is already noted
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [PIX_W-1:0] offset, logic dark_white);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_OFFSET;
    cfg_wdata_i <= offset;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_POLARITY;
    cfg_wdata_i <= {{(PIX_W-1){1'b0}}, dark_white};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_frame(int unsigned acc_len, int unsigned cls_len, bit mark_first);
    for (int unsigned i = 0; i < acc_len; i++)
      send_pixel(KIND_ACCUM, (i == 0) && mark_first, pick_chan(), pick_chan(), pick_chan());
    for (int unsigned i = 0; i < cls_len; i++)
      send_pixel(KIND_CLASSIFY, 1'($urandom_range(0, 1)), pick_chan(), pick_chan(),
                 pick_chan());
  endtask

  initial begin
    int unsigned sent;
    int unsigned acc_len;
    int unsigned cls_len;
    logic [PIX_W-1:0] offset;
    logic             dark_white;
    no_gaps     = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_OFFSET;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_ACCUM;
    first_i     = 1'b0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers, empty frame, first flag on classify items
    send_pixel(KIND_CLASSIFY, 1'b1, 8'd0,   8'd0,   8'd0);
    send_pixel(KIND_CLASSIFY, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(KIND_ACCUM,    1'b1, 8'd255, 8'd255, 8'd255);
    send_pixel(KIND_ACCUM,    1'b0, 8'd0,   8'd0,   8'd0);
    send_pixel(KIND_ACCUM,    1'b0, 8'd1,   8'd1,   8'd0);
    send_pixel(KIND_ACCUM,    1'b0, 8'd2,   8'd2,   8'd2);
    send_pixel(KIND_CLASSIFY, 1'b1, 8'd128, 8'd127, 8'd126);
    send_pixel(KIND_CLASSIFY, 1'b0, 8'd255, 8'd0,   8'd0);
    send_pixel(KIND_CLASSIFY, 1'b0, 8'd0,   8'd255, 8'd255);
    settle();

    // offset above the mean wraps the threshold
    set_regs(8'd255, 1'b0);
    send_pixel(KIND_CLASSIFY, 1'b0, 8'd170, 8'd85,  8'd0);
    send_pixel(KIND_ACCUM,    1'b1, 8'd10,  8'd10,  8'd10);
    send_pixel(KIND_CLASSIFY, 1'b0, 8'd10,  8'd10,  8'd10);
    send_pixel(KIND_CLASSIFY, 1'b0, 8'd0,   8'd0,   8'd0);
    send_pixel(KIND_ACCUM,    1'b0, 8'd200, 8'd200, 8'd200);
    send_pixel(KIND_CLASSIFY, 1'b0, 8'd104, 8'd105, 8'd106);
    send_pixel(KIND_ACCUM,    1'b1, 8'd0,   8'd0,   8'd0);
    send_pixel(KIND_CLASSIFY, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(KIND_CLASSIFY, 1'b0, 8'd0,   8'd0,   8'd2);
    settle();
    set_regs(8'd1, 1'b1);
    send_pixel(KIND_CLASSIFY, 1'b0, 8'd0,   8'd0,   8'd0);
    send_pixel(KIND_CLASSIFY, 1'b1, 8'd255, 8'd255, 8'd254);
    settle();

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       begin offset = 8'd0;   dark_white = 1'b1; end
        1:       begin offset = 8'd255; dark_white = 1'b0; end
        2:       begin offset = 8'd0;   dark_white = 1'b0; end
        3:       begin offset = 8'd255; dark_white = 1'b1; end
        default: begin
          offset     = ph[0] ? PIX_W'($urandom_range(0, 40)) : PIX_W'($urandom_range(0, 255));
          dark_white = 1'($urandom_range(0, 1));
        end
      endcase
      no_gaps = (ph == 2 || ph == 5);
      set_regs(offset, dark_white);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
          sent++;
        end else begin
          acc_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
          cls_len = $urandom_range(1, 24);
          send_frame(acc_len, cls_len, $urandom_range(0, 9) != 0);
          sent += acc_len + cls_len;
        end
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
